// ----- src/wbsd_pkg.sv -----
// ----------------------------------------------------------------------------
// wbsd_pkg
// Types and codes shared by the parts of the WBMP stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package wbsd_pkg;

  // Kind of a result item.
  typedef enum logic [1:0] {
    KIND_DIMS  = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // Error codes carried by an error result.
  typedef enum logic [1:0] {
    ERR_TYPE = 2'd0,
    ERR_EXT  = 2'd1,
    ERR_MB   = 2'd2,
    ERR_DIM  = 2'd3
  } err_t;

  // Commands passed from the header parser to the pixel expander.
  typedef enum logic [1:0] {
    OP_DIMS  = 2'd0,
    OP_ERROR = 2'd1,
    OP_DATA  = 2'd2
  } cmd_op_t;

  // The argument holds the data byte, or the error code in its low bits.
  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] arg;
  } cmd_t;

  // Parser phases.
  typedef enum logic [5:0] {
    PH_TYPE   = 6'b000001,
    PH_FIXED  = 6'b000010,
    PH_WIDTH  = 6'b000100,
    PH_HEIGHT = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_HALT   = 6'b100000
  } phase_t;

  // One result item as it leaves the block.
  typedef struct packed {
    kind_t       kind;
    logic        pixel;
    logic [15:0] column;
    logic [15:0] row;
    logic [15:0] image_width;
    logic [15:0] image_height;
    err_t        error_code;
    logic        last_of_run;
    logic        image_done;
  } res_t;

  localparam int CMD_DEPTH = 4;
  localparam logic [6:0] LOW7_MASK = 7'h7f;

endpackage : wbsd_pkg

`default_nettype wire

// ----- src/wbsd_fifo.sv -----
// ----------------------------------------------------------------------------
// wbsd_fifo
// Small register queue between the header parser and the pixel expander.
// ----------------------------------------------------------------------------
`default_nettype none

module wbsd_fifo #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule : wbsd_fifo

`default_nettype wire

// ----- src/wbsd_front.sv -----
// ----------------------------------------------------------------------------
// wbsd_front
// Header parser: multibyte fields, fixed header byte and dimension checks.
// ----------------------------------------------------------------------------
`default_nettype none

module wbsd_front
  import wbsd_pkg::*;
#(
  parameter int DIM_BITS     = 16,
  parameter int MAX_MB_BYTES = 6
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire logic [7:0]          data_byte,
  output logic                     cmd_wr,
  output cmd_t                     cmd_out,
  output logic      [DIM_BITS-1:0] dim_width,
  output logic      [DIM_BITS-1:0] dim_height
);

  localparam int ACC_W = DIM_BITS + 1;
  localparam int MB_W  = ACC_W + 7;
  localparam int CNT_W = $clog2(MAX_MB_BYTES + 1);
  localparam logic [MB_W-1:0] CAP = MB_W'(1) << DIM_BITS;

  phase_t           phase, phase_next;
  logic [ACC_W-1:0] acc, acc_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [ACC_W-1:0] width_reg, width_reg_next;
  logic [ACC_W-1:0] height_reg, height_reg_next;

  logic [MB_W-1:0]  mb_raw;
  logic [MB_W-1:0]  mb_sat;
  logic [ACC_W-1:0] acc_new;
  logic [CNT_W-1:0] cnt_inc;
  logic             too_long;
  logic             bad_dims;

  // Shift in seven bits and saturate at the first value that is too large.
  assign mb_raw   = {acc, data_byte[6:0]};
  assign mb_sat   = (mb_raw > CAP) ? CAP : mb_raw;
  assign acc_new  = mb_sat[ACC_W-1:0];
  assign cnt_inc  = cnt + CNT_W'(1);
  assign too_long = data_byte[7] && (cnt_inc >= CNT_W'(MAX_MB_BYTES));
  assign bad_dims = (width_reg == '0) || (acc_new == '0) ||
                    width_reg[DIM_BITS] || acc_new[DIM_BITS];

  assign dim_width  = width_reg[DIM_BITS-1:0];
  assign dim_height = height_reg[DIM_BITS-1:0];

  always_comb begin
    phase_next      = phase;
    acc_next        = acc;
    cnt_next        = cnt;
    width_reg_next  = width_reg;
    height_reg_next = height_reg;
    cmd_wr          = 1'b0;
    cmd_out.op      = OP_DATA;
    cmd_out.arg     = data_byte;
    if (fire) begin
      case (phase)
        PH_TYPE, PH_WIDTH, PH_HEIGHT: begin
          if (too_long) begin
            cmd_wr      = 1'b1;
            cmd_out.op  = OP_ERROR;
            cmd_out.arg = {6'd0, ERR_MB};
            phase_next  = PH_HALT;
          end else if (data_byte[7]) begin
            acc_next = acc_new;
            cnt_next = cnt_inc;
          end else begin
            acc_next = '0;
            cnt_next = '0;
            if (phase == PH_TYPE) begin
              if (acc_new != '0) begin
                cmd_wr      = 1'b1;
                cmd_out.op  = OP_ERROR;
                cmd_out.arg = {6'd0, ERR_TYPE};
                phase_next  = PH_HALT;
              end else begin
                phase_next = PH_FIXED;
              end
            end else if (phase == PH_WIDTH) begin
              width_reg_next = acc_new;
              phase_next     = PH_HEIGHT;
            end else begin
              height_reg_next = acc_new;
              cmd_wr          = 1'b1;
              if (bad_dims) begin
                cmd_out.op  = OP_ERROR;
                cmd_out.arg = {6'd0, ERR_DIM};
                phase_next  = PH_HALT;
              end else begin
                cmd_out.op = OP_DIMS;
                phase_next = PH_DATA;
              end
            end
          end
        end
        PH_FIXED: begin
          if ((data_byte[6:0] & LOW7_MASK) != 7'd0) begin
            cmd_wr      = 1'b1;
            cmd_out.op  = OP_ERROR;
            cmd_out.arg = {6'd0, ERR_EXT};
            phase_next  = PH_HALT;
          end else begin
            acc_next   = '0;
            cnt_next   = '0;
            phase_next = PH_WIDTH;
          end
        end
        PH_DATA: begin
          cmd_wr = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TYPE;
      acc        <= '0;
      cnt        <= '0;
      width_reg  <= '0;
      height_reg <= '0;
    end else begin
      phase      <= phase_next;
      acc        <= acc_next;
      cnt        <= cnt_next;
      width_reg  <= width_reg_next;
      height_reg <= height_reg_next;
    end
  end

endmodule : wbsd_front

`default_nettype wire

// ----- src/wbsd_back.sv -----
// ----------------------------------------------------------------------------
// wbsd_back
// Pixel expander: turns queued commands into results, one a cycle if popped.
// ----------------------------------------------------------------------------
`default_nettype none

module wbsd_back
  import wbsd_pkg::*;
#(
  parameter int DIM_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cmd_empty,
  input  cmd_t                     cmd_in,
  output logic                     cmd_pop,
  input  wire logic [DIM_BITS-1:0] dim_width,
  input  wire logic [DIM_BITS-1:0] dim_height,
  output logic                     res_valid,
  output res_t                     res,
  input  wire logic                res_pop
);

  logic                busy, busy_next;
  logic                fin, fin_next;
  logic [2:0]          idx, idx_next;
  logic [7:0]          byte_reg, byte_reg_next;
  logic [DIM_BITS-1:0] col, col_next;
  logic [DIM_BITS-1:0] row, row_next;
  logic [DIM_BITS-1:0] wlast, wlast_next;
  logic [DIM_BITS-1:0] hlast, hlast_next;
  logic                res_valid_next;
  res_t                res_next;

  logic                  adv;
  logic                  emit;
  logic                  do_pix;
  logic [7:0]            cur_byte;
  logic [2:0]            cur_idx;
  logic                  at_wend;
  logic                  done;
  logic                  last;
  logic [DIM_BITS+15:0]  col_ext;
  logic [DIM_BITS+15:0]  row_ext;
  logic [DIM_BITS+15:0]  w_ext;
  logic [DIM_BITS+15:0]  h_ext;

  assign adv      = !res_valid || res_pop;
  assign cur_byte = busy ? byte_reg : cmd_in.arg;
  assign cur_idx  = busy ? idx : 3'd7;
  assign at_wend  = (col == wlast);
  assign done     = at_wend && (row == hlast);
  assign last     = done || (cur_idx == 3'd0);
  assign col_ext  = {16'd0, col};
  assign row_ext  = {16'd0, row};
  assign w_ext    = {16'd0, dim_width};
  assign h_ext    = {16'd0, dim_height};

  always_comb begin
    busy_next      = busy;
    fin_next       = fin;
    idx_next       = idx;
    byte_reg_next  = byte_reg;
    col_next       = col;
    row_next       = row;
    wlast_next     = wlast;
    hlast_next     = hlast;
    res_valid_next = res_valid;
    res_next       = res;
    cmd_pop        = 1'b0;
    emit           = 1'b0;
    do_pix         = 1'b0;
    if (adv) begin
      res_next = '0;
      if (busy) begin
        do_pix = 1'b1;
      end else if (!cmd_empty) begin
        cmd_pop = 1'b1;
        case (cmd_in.op)
          OP_DIMS: begin
            emit                  = 1'b1;
            res_next.kind         = KIND_DIMS;
            res_next.image_width  = w_ext[15:0];
            res_next.image_height = h_ext[15:0];
            res_next.last_of_run  = 1'b1;
            wlast_next            = dim_width - DIM_BITS'(1);
            hlast_next            = dim_height - DIM_BITS'(1);
            col_next              = '0;
            row_next              = '0;
          end
          OP_ERROR: begin
            emit                 = 1'b1;
            res_next.kind        = KIND_ERROR;
            res_next.error_code  = err_t'(cmd_in.arg[1:0]);
            res_next.last_of_run = 1'b1;
          end
          OP_DATA: begin
            do_pix = !fin;
          end
          default: begin
          end
        endcase
      end
      if (do_pix) begin
        emit                 = 1'b1;
        res_next.kind        = KIND_PIXEL;
        res_next.pixel       = cur_byte[cur_idx];
        res_next.column      = col_ext[15:0];
        res_next.row         = row_ext[15:0];
        res_next.last_of_run = last;
        res_next.image_done  = done;
        byte_reg_next        = cur_byte;
        idx_next             = cur_idx - 3'd1;
        busy_next            = !last;
        if (done) begin
          fin_next = 1'b1;
        end else if (at_wend) begin
          col_next = '0;
          row_next = row + DIM_BITS'(1);
        end else begin
          col_next = col + DIM_BITS'(1);
        end
      end
      res_valid_next = emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      fin       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      busy      <= busy_next;
      fin       <= fin_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    byte_reg <= byte_reg_next;
    col      <= col_next;
    row      <= row_next;
    wlast    <= wlast_next;
    hlast    <= hlast_next;
    res      <= res_next;
  end

endmodule : wbsd_back

`default_nettype wire

// ----- src/wbmp_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// wbmp_stream_decoder
// Decoder for type 0 WBMP files, taken one byte per transfer.
// ----------------------------------------------------------------------------
//
//   Channel  | Handshake          | Payload
//   ---------+--------------------+-----------------------------------------
//   input    | push / full        | data_byte
//   result   | empty / pop        | kind, pixel, column, row, image_width,
//            |                    | image_height, error_code, last_of_run,
//            |                    | image_done
//
// Header bytes are taken at one per cycle while the command queue has room.
// A data byte yields up to eight pixel results, issued one per cycle while
// results are popped; the pixel expander paces a stream of data bytes,
// shifting out one bit of its held byte for each result.
// Reset is synchronous and returns the parser to the type field; no result
// is pending after it.
// A four-entry command queue separates the parser from the expander, so
// input transfers continue while results stall, until the queue fills.
// The result register is refilled in the same cycle that it is popped.
//
// ----------------------------------------------------------------------------
`default_nettype none

module wbmp_stream_decoder
  import wbsd_pkg::*;
#(
  parameter int DIM_BITS     = 16,
  parameter int MAX_MB_BYTES = 6
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic      [1:0]  kind,
  output logic             pixel,
  output logic      [15:0] column,
  output logic      [15:0] row,
  output logic      [15:0] image_width,
  output logic      [15:0] image_height,
  output logic      [1:0]  error_code,
  output logic             last_of_run,
  output logic             image_done
);

  localparam int CMD_W = $bits(cmd_t);

  logic                fire;
  logic                cmd_wr;
  cmd_t                cmd_wdata;
  logic [CMD_W-1:0]    cmd_rdata;
  logic                cmd_empty;
  logic                cmd_pop;
  logic [DIM_BITS-1:0] dim_width;
  logic [DIM_BITS-1:0] dim_height;
  logic                res_valid;
  res_t                res;

  // A byte is taken whenever the queue has room; the parser writes at most
  // one command per byte, so that room is always enough.
  assign fire = push && !full;

  wbsd_front #(
    .DIM_BITS     (DIM_BITS),
    .MAX_MB_BYTES (MAX_MB_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .data_byte  (data_byte),
    .cmd_wr     (cmd_wr),
    .cmd_out    (cmd_wdata),
    .dim_width  (dim_width),
    .dim_height (dim_height)
  );

  wbsd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_wr),
    .wr_data (cmd_wdata),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_rdata),
    .empty   (cmd_empty)
  );

  // The dimensions are read straight from the parser: they are settled by
  // the time the dimensions command is queued and do not change afterwards.
  wbsd_back #(
    .DIM_BITS (DIM_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_empty  (cmd_empty),
    .cmd_in     (cmd_t'(cmd_rdata)),
    .cmd_pop    (cmd_pop),
    .dim_width  (dim_width),
    .dim_height (dim_height),
    .res_valid  (res_valid),
    .res        (res),
    .res_pop    (pop)
  );

  assign empty        = !res_valid;
  assign kind         = res.kind;
  assign pixel        = res.pixel;
  assign column       = res.column;
  assign row          = res.row;
  assign image_width  = res.image_width;
  assign image_height = res.image_height;
  assign error_code   = res.error_code;
  assign last_of_run  = res.last_of_run;
  assign image_done   = res.image_done;

endmodule : wbmp_stream_decoder

`default_nettype wire

// ----- src/wbsd_checker.sv -----
// ----------------------------------------------------------------------------
// wbsd_checker
// Port-level checks for the WBMP stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wbsd_checker
  import wbsd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [1:0]  kind,
  input wire logic        pixel,
  input wire logic [15:0] column,
  input wire logic [15:0] row,
  input wire logic        last_of_run,
  input wire logic        image_done
);

  // A result that waits keeps its kind, pixel, column and row until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(kind) && $stable(pixel) &&
                          $stable(column) && $stable(row)))
    else $error("waiting result changed before transfer");

  // Errors and the final pixel always close the run of their byte.
  a_close: assert property (@(posedge clk) disable iff (rst)
    (!empty && (kind == KIND_ERROR || image_done)) |-> last_of_run)
    else $error("error or final pixel without last_of_run");

  // Nothing follows an error.
  a_err_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && kind == KIND_ERROR) |=> empty)
    else $error("result after an error");

  // Nothing follows the final pixel of the image.
  a_img_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && image_done) |=> empty)
    else $error("result after the final pixel");

endmodule : wbsd_checker

bind wbmp_stream_decoder wbsd_checker u_wbsd_checker (
  .clk         (clk),
  .rst         (rst),
  .empty       (empty),
  .pop         (pop),
  .kind        (kind),
  .pixel       (pixel),
  .column      (column),
  .row         (row),
  .last_of_run (last_of_run),
  .image_done  (image_done)
);

`default_nettype wire

// ----- tb/wbmp_stream_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// wbmp_stream_decoder_tb
// Self-checking bench for the WBMP stream decoder. Byte streams are built
// up front and fed through the push/full port, while a behavioural decoder
// predicts every dimensions, pixel and error result. Results popped from
// the block are checked against the oldest prediction, field by field.
// ----------------------------------------------------------------------------

module wbmp_stream_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wbsd_pkg::*;

  localparam int DIM_BITS     = 16;
  localparam int MAX_MB_BYTES = 6;
  localparam longint unsigned DIM_CAP = 64'd1 << DIM_BITS;

  // The bench aims for roughly this many pixels in a clean image, which is
  // about one hundred and ten data bytes.
  localparam int TARGET_PIXELS  = 880;
  // A spoilt header is padded with trailing bytes up to about this length.
  localparam int TARGET_BYTES   = 110;
  localparam int MAX_REPORTS    = 10;
  localparam int DRAIN_CYCLES   = 100;
  localparam int WATCHDOG_LIMIT = 2000;

  // Ways in which a header can be spoilt. A run is either a clean image or
  // one of these, since errors are terminal and reset is applied only once.
  typedef enum int {
    FLAW_TYPE_VALUE,
    FLAW_TYPE_SATURATED,
    FLAW_EXTENSION,
    FLAW_TOO_LONG,
    FLAW_ZERO_DIM,
    FLAW_HUGE_DIM
  } header_flaw_t;

  // Progress of the multibyte field parser after one byte.
  typedef enum int {
    MB_MORE,
    MB_COMPLETE,
    MB_TOO_LONG
  } mb_status_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  kind;
  logic        pixel;
  logic [15:0] column;
  logic [15:0] row;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [1:0]  error_code;
  logic        last_of_run;
  logic        image_done;

  wbmp_stream_decoder #(
    .DIM_BITS    (DIM_BITS),
    .MAX_MB_BYTES(MAX_MB_BYTES)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .data_byte   (data_byte),
    .empty       (empty),
    .pop         (pop),
    .kind        (kind),
    .pixel       (pixel),
    .column      (column),
    .row         (row),
    .image_width (image_width),
    .image_height(image_height),
    .error_code  (error_code),
    .last_of_run (last_of_run),
    .image_done  (image_done)
  );

  // Bytes of the file still to be transferred; the head is the byte that
  // the driver currently offers.
  logic [7:0] file_bytes_q[$];
  // Results that the behavioural decoder has produced but the block has
  // not yet delivered.
  res_t       decoder_output_q[$];

  int   total_bytes = 0;
  int   taken_count = 0;
  logic byte_taken = 1'b0;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   fault_count = 0;
  int   stall_cycles = 0;
  res_t seen;
  res_t want;

  // Behavioural decoder state, at the block's widths except the accumulator.
  // The dimension registers carry one extra bit to hold a saturated value.
  phase_t              dec_phase = PH_TYPE;
  logic [31:0]         mb_acc = '0;
  logic [2:0]          mb_count = '0;
  logic [DIM_BITS:0]   img_w = '0;
  logic [DIM_BITS:0]   img_h = '0;
  logic [DIM_BITS-1:0] col_pos = '0;
  logic [DIM_BITS-1:0] row_pos = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Behavioural decoder
  // --------------------------------------------------------------------------

  // An error ends the stream: the parser halts and one error result is due.
  task automatic flag_error(input err_t code);
    res_t r;
    r = '0;
    r.kind        = KIND_ERROR;
    r.error_code  = code;
    r.last_of_run = 1'b1;
    dec_phase = PH_HALT;
    decoder_output_q.push_back(r);
  endtask

  // Shifts one byte into the multibyte accumulator, which saturates at the
  // dimension cap so that an oversized value can never wrap back to a
  // legal one.
  function automatic mb_status_t feed_multibyte(input logic [7:0] b);
    logic [63:0] v;
    v = ({32'd0, mb_acc} << 7) | 64'(b[6:0]);
    if (v > DIM_CAP)
      v = DIM_CAP;
    mb_acc   = v[31:0];
    mb_count = mb_count + 3'd1;
    if (b[7])
      return (mb_count >= 3'(MAX_MB_BYTES)) ? MB_TOO_LONG : MB_MORE;
    return MB_COMPLETE;
  endfunction

  // Works out every result that one accepted byte gives rise to.
  task automatic decode_wbmp_byte(input logic [7:0] b);
    res_t              r;
    mb_status_t        status;
    logic [DIM_BITS:0] field_val;
    logic              done;
    logic              finished;
    int                bit_idx;
    r = '0;
    case (dec_phase)
      PH_TYPE, PH_WIDTH, PH_HEIGHT: begin
        status = feed_multibyte(b);
        if (status == MB_TOO_LONG) begin
          flag_error(ERR_MB);
        end else if (status == MB_COMPLETE) begin
          field_val = mb_acc[DIM_BITS:0];
          mb_acc    = '0;
          mb_count  = '0;
          if (dec_phase == PH_TYPE) begin
            if (field_val != '0)
              flag_error(ERR_TYPE);
            else
              dec_phase = PH_FIXED;
          end else if (dec_phase == PH_WIDTH) begin
            img_w     = field_val;
            dec_phase = PH_HEIGHT;
          end else begin
            img_h = field_val;
            if (img_w == '0 || img_h == '0 || img_w >= DIM_CAP || img_h >= DIM_CAP) begin
              flag_error(ERR_DIM);
            end else begin
              dec_phase      = PH_DATA;
              col_pos        = '0;
              row_pos        = '0;
              r.kind         = KIND_DIMS;
              r.image_width  = img_w[15:0];
              r.image_height = img_h[15:0];
              r.last_of_run  = 1'b1;
              decoder_output_q.push_back(r);
            end
          end
        end
      end
      PH_FIXED: begin
        if ((b[6:0] & LOW7_MASK) != '0) begin
          flag_error(ERR_EXT);
        end else begin
          dec_phase = PH_WIDTH;
          mb_acc    = '0;
          mb_count  = '0;
        end
      end
      PH_DATA: begin
        finished = 1'b0;
        for (bit_idx = 7; bit_idx >= 0 && !finished; bit_idx--) begin
          done = (({1'b0, col_pos} + 1'b1) >= img_w) && (({1'b0, row_pos} + 1'b1) >= img_h);
          r             = '0;
          r.kind        = KIND_PIXEL;
          r.pixel       = b[bit_idx];
          r.column      = col_pos[15:0];
          r.row         = row_pos[15:0];
          r.last_of_run = done || bit_idx == 0;
          r.image_done  = done;
          decoder_output_q.push_back(r);
          if (done) begin
            dec_phase = PH_HALT;
            finished  = 1'b1;
          end else begin
            col_pos = col_pos + 1'b1;
            if ({1'b0, col_pos} >= img_w) begin
              col_pos = '0;
              row_pos = row_pos + 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Stream construction
  // --------------------------------------------------------------------------

  // Appends a multibyte integer, most significant group first, after a run
  // of redundant zero groups that only lengthen the field.
  task automatic add_multibyte(input logic [31:0] value, input int pad);
    int          groups;
    logic [31:0] rest;
    groups = 1;
    rest   = value >> 7;
    while (rest != 0) begin
      groups++;
      rest = rest >> 7;
    end
    repeat (pad) file_bytes_q.push_back(8'h80);
    for (int g = groups - 1; g >= 0; g--)
      file_bytes_q.push_back({g != 0, 7'(value >> (7 * g))});
  endtask

  // A legal type field followed by a legal fixed header byte. Bit 7 of the
  // fixed byte is allowed and is set at random.
  task automatic add_header_lead();
    add_multibyte(32'd0, $urandom_range(0, 5));
    file_bytes_q.push_back(($urandom_range(1) != 0) ? 8'h80 : 8'h00);
  endtask

  task automatic build_clean_image();
    int w;
    int h;
    int n_data;
    add_header_lead();
    // Mostly narrow images with many rows; now and then a wide one with
    // few rows, so that both counters see a fair range.
    if ($urandom_range(3) == 0)
      w = $urandom_range(100, TARGET_PIXELS);
    else
      w = $urandom_range(1, 70);
    h      = (TARGET_PIXELS + w - 1) / w;
    n_data = (w * h + 7) / 8;
    add_multibyte(w, $urandom_range(0, 4));
    add_multibyte(h, $urandom_range(0, 4));
    // All-black and all-white bytes open the data, then random content.
    // The final byte may be only partly used when the pixel count is not a
    // multiple of eight.
    file_bytes_q.push_back(8'h00);
    file_bytes_q.push_back(8'hff);
    for (int i = 2; i < n_data; i++)
      file_bytes_q.push_back(8'($urandom_range(255)));
  endtask

  task automatic build_broken_header(input header_flaw_t flaw);
    int          pick;
    logic [31:0] w;
    logic [31:0] h;
    case (flaw)
      FLAW_TYPE_VALUE: begin
        add_multibyte($urandom_range(1, 16383), $urandom_range(0, 3));
      end
      FLAW_TYPE_SATURATED: begin
        add_multibyte($urandom_range(32'h0001_0000, 32'h00ff_ffff), 0);
      end
      FLAW_EXTENSION: begin
        add_multibyte(32'd0, $urandom_range(0, 5));
        file_bytes_q.push_back({$urandom_range(1) != 0, 7'($urandom_range(1, 127))});
      end
      FLAW_TOO_LONG: begin
        // The over-long field may be the type, the width or the height.
        pick = $urandom_range(2);
        if (pick > 0)
          add_header_lead();
        if (pick > 1)
          add_multibyte($urandom_range(1, 65535), $urandom_range(0, 2));
        repeat (MAX_MB_BYTES) file_bytes_q.push_back(8'h80 | 8'($urandom_range(127)));
      end
      FLAW_ZERO_DIM: begin
        add_header_lead();
        pick = $urandom_range(2);
        w = (pick == 1) ? $urandom_range(1, 65535) : 32'd0;
        h = (pick == 0) ? $urandom_range(1, 65535) : 32'd0;
        add_multibyte(w, $urandom_range(0, 2));
        add_multibyte(h, $urandom_range(0, 2));
      end
      default: begin
        add_header_lead();
        pick = $urandom_range(1);
        w = pick ? $urandom_range(32'h0001_0000, 32'h00ff_ffff) : $urandom_range(1, 65535);
        h = pick ? $urandom_range(1, 65535) : $urandom_range(32'h0001_0000, 32'h00ff_ffff);
        add_multibyte(w, $urandom_range(0, 2));
        add_multibyte(h, $urandom_range(0, 2));
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Reporting
  // --------------------------------------------------------------------------

  function automatic string describe(input res_t r);
    return $sformatf("kind=%0d pixel=%0d col=%0d row=%0d w=%0d h=%0d err=%0d last=%0d done=%0d",
                     r.kind, r.pixel, r.column, r.row, r.image_width, r.image_height,
                     r.error_code, r.last_of_run, r.image_done);
  endfunction

  task automatic note_fault(input string what, input res_t exp_r, input res_t got_r);
    fault_count++;
    if (fault_count <= MAX_REPORTS)
      $display("%0t: %s\n  expected %s\n  actual   %s", $time, what,
               describe(exp_r), describe(got_r));
  endtask

  // --------------------------------------------------------------------------
  // Idling profile
  // --------------------------------------------------------------------------

  // The first third of the stream sees a mostly stalled receiver, the
  // second third a mostly idle sender, and the rest runs flat out.
  always_comb begin
    if (taken_count < total_bytes / 3) begin
      send_idle_pct = 6;
      recv_idle_pct = 67;
    end else if (taken_count < (2 * total_bytes) / 3) begin
      send_idle_pct = 67;
      recv_idle_pct = 6;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // --------------------------------------------------------------------------
  // Driver
  // --------------------------------------------------------------------------

  // Inputs move on the falling edge. An offered byte is held until its
  // transfer has been seen at a rising edge; only then may the next one be
  // offered, or push be dropped.
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || byte_taken) begin
      if (file_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        push      <= 1'b1;
        data_byte <= file_bytes_q[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // The receiver stalls at random, independent of whether a result waits.
  always @(negedge clk) begin
    if (rst)
      pop <= 1'b0;
    else
      pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor and scoreboard
  // --------------------------------------------------------------------------

  // Both transfers are judged on the values that stand just before the
  // rising edge. The input side is handled first, so an expectation is in
  // place before any result that it could explain is checked.
  always @(posedge clk) begin
    byte_taken <= !rst && push && !full;
    if (!rst) begin
      if (push && !full) begin
        decode_wbmp_byte(data_byte);
        void'(file_bytes_q.pop_front());
        taken_count <= taken_count + 1;
      end
      if (pop && !empty) begin
        seen.kind         = kind_t'(kind);
        seen.pixel        = pixel;
        seen.column       = column;
        seen.row          = row;
        seen.image_width  = image_width;
        seen.image_height = image_height;
        seen.error_code   = err_t'(error_code);
        seen.last_of_run  = last_of_run;
        seen.image_done   = image_done;
        if (decoder_output_q.size() == 0) begin
          note_fault("result transferred with nothing expected", res_t'(0), seen);
        end else begin
          want = decoder_output_q.pop_front();
          if (seen.kind !== want.kind || seen.pixel !== want.pixel ||
              seen.column !== want.column || seen.row !== want.row ||
              seen.image_width !== want.image_width ||
              seen.image_height !== want.image_height ||
              seen.error_code !== want.error_code ||
              seen.last_of_run !== want.last_of_run ||
              seen.image_done !== want.image_done)
            note_fault("result mismatch", want, seen);
        end
      end
    end
  end

  // The watchdog counts cycles in which neither side completes a transfer.
  // Random stalls at the rates used here never come near the limit, so
  // reaching it means the block has hung or lost results.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------

  initial begin
    // Most runs decode a whole image; one in five spoils the header in one
    // of several ways. Either way some trailing bytes follow, which the
    // block must swallow without a result once it has halted.
    if ($urandom_range(4) != 0) begin
      build_clean_image();
      repeat (4) file_bytes_q.push_back(8'($urandom_range(255)));
    end else begin
      build_broken_header(header_flaw_t'($urandom_range(5)));
      while (file_bytes_q.size() < TARGET_BYTES)
        file_bytes_q.push_back(8'($urandom_range(255)));
    end
    total_bytes = file_bytes_q.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Every byte must be transferred and every prediction met; then a
    // margin of cycles lets any stray result show itself.
    while (file_bytes_q.size() != 0 || decoder_output_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_count == 0 && decoder_output_q.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule : wbmp_stream_decoder_tb
